// ===== src/smcs_pkg.sv =====
// Package for the sparse matrix coordinate store.
// Holds sizes, item structs, the controller state type and the key helper.
// No dependencies.
package smcs_pkg;

  localparam int CAPACITY   = 64;
  localparam int INDEX_BITS = 16;
  localparam int VALUE_BITS = 32;

  localparam int ROW_FIELD_W = 16;
  localparam int VAL_FIELD_W = 32;
  localparam int USED_W      = 7;

  localparam int ROW_KEY_W = (INDEX_BITS < ROW_FIELD_W) ? INDEX_BITS : ROW_FIELD_W;
  localparam int KEY_W     = 2 * ROW_KEY_W;
  localparam int VAL_W     = (VALUE_BITS < VAL_FIELD_W) ? VALUE_BITS : VAL_FIELD_W;
  localparam int ADDR_W    = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  typedef enum logic {
    ACT_READ  = 1'b0,
    ACT_WRITE = 1'b1
  } action_e;

  typedef struct packed {
    logic                          action;
    logic [ROW_FIELD_W-1:0]        row;
    logic [ROW_FIELD_W-1:0]        col;
    logic signed [VAL_FIELD_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic signed [VAL_FIELD_W-1:0] read_value;
    logic                          found;
    logic                          status;
    logic [USED_W-1:0]             entries_used;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_LOOK,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic capture;
    logic match_en;
    logic look_en;
    logic exec_en;
  } ctrl_t;

  function automatic logic [KEY_W-1:0] key_of(input logic [ROW_FIELD_W-1:0] row,
                                               input logic [ROW_FIELD_W-1:0] col);
    key_of = {row[ROW_KEY_W-1:0], col[ROW_KEY_W-1:0]};
  endfunction

endpackage

// ===== src/sparse_matrix_coordinate_store.sv =====
// Top level of the sparse matrix coordinate store.
// Depends on smcs_pkg, smcs_ctrl, smcs_datapath (and smcs_ram below it).
//
// Usage:
//   Present an item on cmd_i and raise start; the item is taken at the
//   rising edge where start is high and busy is low. action selects a
//   read or a write; a write of a zero value deletes the entry, moving
//   the last entry into its slot.
//   Each item gives exactly one result on res_o, marked by res_valid_o
//   for one cycle. The receiver cannot stall: take the result in that
//   cycle or lose it.
//   After acceptance the item passes the match, lookup and execute
//   steps; the result and its strobe are registered as execute ends.
//   busy stays high for the match, lookup and execute steps, so no
//   new item is taken before the last one is through. The next item
//   may be taken in the cycle that shows the previous result.
//   The match step compares the key against every live slot at once
//   in key cells; the value RAM read port is used twice per item
//   (last entry, then matched slot), which sets the step count.
//   Reset clears the count, match bits and result strobe; slots are
//   count-qualified, so no clearing pass is needed; ready at once.
module sparse_matrix_coordinate_store (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  smcs_pkg::cmd_t    cmd_i,
  output logic              res_valid_o,
  output smcs_pkg::result_t res_o
);
  import smcs_pkg::*;

  ctrl_t ctrl;

  // sequence the four steps of an item
  smcs_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .ctrl_o (ctrl)
  );

  // hold keys, values and count; drive the result
  smcs_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .cmd_i       (cmd_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

// ===== src/smcs_ram.sv =====
// Generic single write port RAM with one registered read port.
// No dependencies.
module smcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/smcs_ctrl.sv =====
// Controller state machine of the coordinate store.
// Depends on smcs_pkg for the state and control types.
module smcs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  output smcs_pkg::ctrl_t     ctrl_o
);
  import smcs_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (start) state_d = ST_MATCH;
      ST_MATCH: state_d = ST_LOOK;
      ST_LOOK:  state_d = ST_EXEC;
      ST_EXEC:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    busy   = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy           = 1'b0;
        ctrl_o.capture = start;
      end
      ST_MATCH: ctrl_o.match_en = 1'b1;
      ST_LOOK:  ctrl_o.look_en  = 1'b1;
      ST_EXEC:  ctrl_o.exec_en  = 1'b1;
      default:  busy = 1'b0;
    endcase
  end

endmodule

// ===== src/smcs_datapath.sv =====
// Datapath of the coordinate store: key cells, key and value RAMs, entry count.
// Depends on smcs_pkg and smcs_ram.
module smcs_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  smcs_pkg::ctrl_t   ctrl_i,
  input  smcs_pkg::cmd_t    cmd_i,
  output logic              res_valid_o,
  output smcs_pkg::result_t res_o
);
  import smcs_pkg::*;

  cmd_t              cmd_q;
  logic [KEY_W-1:0]  key_cells_q [CAPACITY];
  logic [CAPACITY-1:0] match_q, match_d;
  logic [CNT_W-1:0]  total_q, total_d;
  logic [ADDR_W-1:0] slot_q, slot_c, last_c;
  logic              hit_q, hit_c;
  logic [KEY_W-1:0]  last_key_q;
  logic [VAL_W-1:0]  last_val_q;
  logic              res_valid_q;
  result_t           res_q, res_d;

  logic [KEY_W-1:0]  key_c;
  logic [VAL_W-1:0]  val_c;
  logic              vzero_c, room_c;
  logic              ins_c, upd_c, del_c;

  logic              key_we, val_we;
  logic [ADDR_W-1:0] waddr_c, val_raddr_c;
  logic [KEY_W-1:0]  key_wdata_c, key_rdata;
  logic [VAL_W-1:0]  val_wdata_c, val_rdata;

  assign key_c   = key_of(cmd_q.row, cmd_q.col);
  assign val_c   = cmd_q.value[VAL_W-1:0];
  assign vzero_c = (val_c == '0);
  assign room_c  = (total_q < CNT_W'(CAPACITY));
  assign last_c  = ADDR_W'(total_q - CNT_W'(1));

  // compare against every live slot in parallel
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match_d[i] = (key_cells_q[i] == key_c) && (CNT_W'(i) < total_q);
    end
  end

  // keys are unique, so the slot number is an OR of the matching indices
  always_comb begin
    slot_c = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match_q[i]) slot_c = slot_c | ADDR_W'(i);
    end
    hit_c = |match_q;
  end

  assign ins_c = ctrl_i.exec_en && (cmd_q.action == ACT_WRITE) && !vzero_c && !hit_q && room_c;
  assign upd_c = ctrl_i.exec_en && (cmd_q.action == ACT_WRITE) && !vzero_c && hit_q;
  assign del_c = ctrl_i.exec_en && (cmd_q.action == ACT_WRITE) && vzero_c && hit_q;

  assign key_we      = ins_c || del_c;
  assign val_we      = ins_c || upd_c || del_c;
  assign waddr_c     = ins_c ? total_q[ADDR_W-1:0] : slot_q;
  assign key_wdata_c = del_c ? last_key_q : key_c;
  assign val_wdata_c = del_c ? last_val_q : val_c;
  assign val_raddr_c = ctrl_i.look_en ? slot_c : last_c;

  smcs_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (waddr_c),
    .wdata_i (key_wdata_c),
    .raddr_i (last_c),
    .rdata_o (key_rdata)
  );

  smcs_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (waddr_c),
    .wdata_i (val_wdata_c),
    .raddr_i (val_raddr_c),
    .rdata_o (val_rdata)
  );

  always_comb begin
    total_d = total_q;
    if (ins_c) total_d = total_q + CNT_W'(1);
    else if (del_c) total_d = total_q - CNT_W'(1);
  end

  always_comb begin
    res_d              = '0;
    res_d.found        = hit_q;
    res_d.status       = (cmd_q.action == ACT_WRITE) && !vzero_c && !hit_q && !room_c;
    res_d.entries_used = USED_W'(total_d);
    if ((cmd_q.action == ACT_READ) && hit_q) begin
      res_d.read_value = VAL_FIELD_W'(val_rdata);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) cmd_q <= cmd_i;
    if (ctrl_i.look_en) begin
      slot_q     <= slot_c;
      hit_q      <= hit_c;
      last_key_q <= key_rdata;
      last_val_q <= val_rdata;
    end
    if (key_we) key_cells_q[waddr_c] <= key_wdata_c;
    if (ctrl_i.exec_en) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      match_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      total_q     <= total_d;
      res_valid_q <= ctrl_i.exec_en;
      if (ctrl_i.match_en) match_q <= match_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_unique_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match_q))
    else $error("key matched in more than one slot");

  a_full_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.status |-> !res_q.found)
    else $error("full reported on a hit");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctrl_i.exec_en |=> $stable(total_q))
    else $error("entry count moved outside execute");

endmodule
